/* rtl/ple_pkg.sv */
// shared types and constants for the positional list engine
// depends on nothing; used by every module under rtl
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam logic [LEN_W-1:0] CAPACITY_LEN = LEN_W'(CAPACITY);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_GET    = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } rsp_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic execute;
    } ctrl_t;

endpackage

/* rtl/positional_list_engine_unit.sv */
// Ordered list of up to 16 32-bit words with append, insert, get and remove at
// a position; every request gives one response carrying status and new length.
// Each transaction first registers the request, then updates the entry cells,
// which all shift at once, and loads the response register; the update waits
// while a held response blocks the output. A new request is taken while an
// earlier response still waits, but not while one is executing. No clearing is
// needed after reset. Depends on ple_pkg, ple_ctrl and ple_datapath.
module positional_list_engine_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ple_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ple_pkg::rsp_t rsp
);

    ple_pkg::ctrl_t ctrl;

    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    ple_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl),
        .rsp   (rsp)
    );

endmodule

/* rtl/ple_ctrl.sv */
// controller for the positional list engine: request handshake, response valid
// depends on ple_pkg
module ple_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ple_pkg::ctrl_t ctrl
);

    ple_pkg::state_t state_reg, state_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ple_pkg::S_EXEC;
                end
            end
            ple_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall    = 1'b1;
        ctrl.load    = 1'b0;
        ctrl.execute = 1'b0;
        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                ctrl.load = req_valid;
            end
            ple_pkg::S_EXEC:
            begin
                ctrl.execute = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/ple_datapath.sv */
// datapath for the positional list engine: request register, shifting entry
// cells, length counter and response register; depends on ple_pkg
module ple_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  ple_pkg::req_t  req,
    input  ple_pkg::ctrl_t ctrl,
    output ple_pkg::rsp_t  rsp
);

    ple_pkg::req_t req_reg;
    ple_pkg::rsp_t rsp_reg, rsp_next;

    logic [ple_pkg::DATA_W-1:0] entries_reg  [ple_pkg::CAPACITY];
    logic [ple_pkg::DATA_W-1:0] entries_next [ple_pkg::CAPACITY];
    logic [ple_pkg::LEN_W-1:0]  count_reg, count_next;

    logic                        is_write;
    logic                        bad_pos;
    logic                        full;
    logic                        ok;
    logic [ple_pkg::LEN_W-1:0]   pos_len;
    logic [ple_pkg::LEN_W-1:0]   ins_pos;
    logic [ple_pkg::DATA_W-1:0]  read_word;

    assign is_write = (req_reg.command == ple_pkg::CMD_APPEND)
                   || (req_reg.command == ple_pkg::CMD_INSERT);
    assign pos_len  = ple_pkg::LEN_W'(req_reg.position);
    // append is an insert at the current length
    assign ins_pos  = (req_reg.command == ple_pkg::CMD_APPEND) ? count_reg : pos_len;
    assign bad_pos  = is_write ? (ins_pos > count_reg) : (pos_len >= count_reg);
    assign full     = is_write && (count_reg == ple_pkg::CAPACITY_LEN);
    assign ok       = !bad_pos && !full;
    assign read_word = entries_reg[req_reg.position[ple_pkg::IDX_W-1:0]];

    // every cell picks from itself, its neighbors or the new value
    always_comb
    begin
        for (int i = 0; i < ple_pkg::CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (ctrl.execute && ok)
            begin
                if (is_write)
                begin
                    if (ple_pkg::LEN_W'(i) == ins_pos)
                    begin
                        entries_next[i] = req_reg.value;
                    end
                    else if (ple_pkg::LEN_W'(i) > ins_pos && i > 0)
                    begin
                        entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                else if (req_reg.command == ple_pkg::CMD_REMOVE)
                begin
                    if (ple_pkg::LEN_W'(i) >= pos_len && i < ple_pkg::CAPACITY - 1)
                    begin
                        entries_next[i] =
                            entries_reg[(i < ple_pkg::CAPACITY - 1) ? i + 1 : i];
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (ctrl.execute)
        begin
            rsp_next.read_value = '0;
            if (bad_pos)
            begin
                rsp_next.status = ple_pkg::ST_BAD_POS;
            end
            else if (full)
            begin
                rsp_next.status = ple_pkg::ST_FULL;
            end
            else
            begin
                rsp_next.status = ple_pkg::ST_OK;
                case (req_reg.command) inside
                    ple_pkg::CMD_APPEND, ple_pkg::CMD_INSERT:
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    ple_pkg::CMD_GET:
                    begin
                        rsp_next.read_value = read_word;
                    end
                    default:
                    begin
                        rsp_next.read_value = read_word;
                        count_next          = count_reg - 1'b1;
                    end
                endcase
            end
            rsp_next.length = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg <= req;
        end
        rsp_reg     <= rsp_next;
        entries_reg <= entries_next;
    end

    assign rsp = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CAPACITY_LEN)
        else $error("list length above capacity");

    a_length_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> rsp_reg.length == count_reg)
        else $error("response length differs from list length");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute && !ok |=> count_reg == $past(count_reg))
        else $error("rejected request changed the length");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute && !ok |=> rsp_reg.read_value == '0)
        else $error("rejected request returned data");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.execute))
        else $error("request loaded while another executes");

endmodule

/* tb/tb.sv */
// self-checking testbench for positional_list_engine_unit: a queue-fed driver with
// a list predictor for accepted requests, a response monitor, and an idle-cycle watchdog
// depends on rtl/ple_pkg.sv and rtl/positional_list_engine_unit.sv
module tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_TAIL  = 20;
    localparam int RAND_ITEMS  = 1600;

    typedef struct {
        ple_pkg::req_t rq;
        bit            hold;
    } pending_req_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    ple_pkg::req_t req = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    ple_pkg::rsp_t rsp;

    pending_req_t  request_q[$];
    ple_pkg::rsp_t expected_rsp_q[$];

    // predictor copy of the list
    logic [ple_pkg::DATA_W-1:0] model_words [ple_pkg::CAPACITY];
    int                         model_len = 0;

    // generator shadow of the list length
    int gen_len = 0;

    int mismatch_count = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_run = 0;

    positional_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic ple_pkg::rsp_t predict_list_response(ple_pkg::req_t r);
        ple_pkg::rsp_t res;
        int            p;
        int            i;
        res.status = ple_pkg::ST_OK;
        res.read_value = '0;
        p = int'(r.position);
        case (r.command)
            ple_pkg::CMD_APPEND:
            begin
                if (model_len >= ple_pkg::CAPACITY)
                    res.status = ple_pkg::ST_FULL;
                else
                begin
                    model_words[model_len] = r.value;
                    model_len++;
                end
            end
            ple_pkg::CMD_INSERT:
            begin
                // a bad position wins over a full list
                if (p > model_len)
                    res.status = ple_pkg::ST_BAD_POS;
                else if (model_len >= ple_pkg::CAPACITY)
                    res.status = ple_pkg::ST_FULL;
                else
                begin
                    for (i = model_len; i > p; i--)
                        model_words[i] = model_words[i-1];
                    model_words[p] = r.value;
                    model_len++;
                end
            end
            ple_pkg::CMD_GET:
            begin
                if (p >= model_len)
                    res.status = ple_pkg::ST_BAD_POS;
                else
                    res.read_value = model_words[p];
            end
            default:
            begin
                if (p >= model_len)
                    res.status = ple_pkg::ST_BAD_POS;
                else
                begin
                    res.read_value = model_words[p];
                    for (i = p; i + 1 < model_len; i++)
                        model_words[i] = model_words[i+1];
                    model_len--;
                end
            end
        endcase
        res.length = ple_pkg::LEN_W'(model_len);
        return res;
    endfunction

    function automatic int length_after(int len, ple_pkg::req_t r);
        case (r.command)
            ple_pkg::CMD_APPEND: return (len < ple_pkg::CAPACITY) ? len + 1 : len;
            ple_pkg::CMD_INSERT:
                return (int'(r.position) <= len && len < ple_pkg::CAPACITY) ? len + 1
                                                                             : len;
            ple_pkg::CMD_GET:    return len;
            default:             return (int'(r.position) < len) ? len - 1 : len;
        endcase
    endfunction

    task automatic add_item(input ple_pkg::cmd_t c, input int pos,
                            input logic [ple_pkg::DATA_W-1:0] val, input bit hold);
        pending_req_t item;
        item.rq.command = c;
        item.rq.position = ple_pkg::POS_W'(pos);
        item.rq.value = val;
        item.hold = hold;
        gen_len = length_after(gen_len, item.rq);
        request_q.push_back(item);
    endtask

    function automatic logic [ple_pkg::DATA_W-1:0] random_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return ple_pkg::DATA_W'($urandom);
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk)
    begin
        logic          nv;
        ple_pkg::req_t nreq;
        pending_req_t  item;
        nv = 1'b0;
        nreq = req;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_list_response(req));
            if (req_valid && req_stall)
                nv = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (request_q.size() > 0 &&
                     (!request_q[0].hold || expected_rsp_q.size() == 0))
            begin
                item = request_q.pop_front();
                nv = 1'b1;
                nreq = item.rq;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(0, 25);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            req_valid <= nv;
            req <= nreq;
        end
    end

    // monitor: compare each accepted response, then pick the next stall value
    always @(posedge clk)
    begin
        logic          ns;
        ple_pkg::rsp_t want;
        ns = 1'b0;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %h want %h",
                                                  rsp.read_value, want.read_value));
                    if (rsp.length !== want.length)
                        report_mismatch($sformatf("length got %0d want %0d",
                                                  rsp.length, want.length));
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0: ns = 1'b0;
                1: ns = ($urandom_range(0, 2) == 0);
                2: ns = ~rsp_stall;
                default:
                begin
                    // runs of stall and release of random length
                    if (stall_run == 0)
                    begin
                        ns = ~rsp_stall;
                        stall_run = $urandom_range(1, 8);
                    end
                    else
                    begin
                        ns = rsp_stall;
                        stall_run--;
                    end
                end
            endcase
            rsp_stall <= ns;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("positional_list_engine_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int            n;
        int            sel;
        int            pos;
        bit            filling;
        ple_pkg::cmd_t c;

        // cases starting from an empty list
        add_item(ple_pkg::CMD_GET, 0, '0, 1'b0);
        add_item(ple_pkg::CMD_REMOVE, 0, '0, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 1, 32'h1234_5678, 1'b0);
        add_item(ple_pkg::CMD_GET, 31, '0, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 0, '1, 1'b0);
        add_item(ple_pkg::CMD_APPEND, 27, '0, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 2, 32'h5555_5555, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 0, 32'haaaa_aaaa, 1'b0);
        add_item(ple_pkg::CMD_GET, 3, '0, 1'b0);
        add_item(ple_pkg::CMD_REMOVE, 1, '0, 1'b0);
        while (gen_len < ple_pkg::CAPACITY)
            add_item(ple_pkg::CMD_APPEND, 0, random_word(), 1'b0);
        // full list cases
        add_item(ple_pkg::CMD_APPEND, 0, 32'hdead_beef, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 0, 32'hdead_beef, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 16, 32'hdead_beef, 1'b0);
        add_item(ple_pkg::CMD_INSERT, 17, 32'hdead_beef, 1'b0);
        add_item(ple_pkg::CMD_GET, 15, '0, 1'b0);
        add_item(ple_pkg::CMD_GET, 16, '0, 1'b0);
        add_item(ple_pkg::CMD_REMOVE, 15, '0, 1'b0);
        add_item(ple_pkg::CMD_REMOVE, 0, '0, 1'b0);
        add_item(ple_pkg::CMD_REMOVE, 31, '0, 1'b0);

        filling = 1'b0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (filling && gen_len == ple_pkg::CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && gen_len == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 59) == 0)
                filling = ~filling;
            sel = $urandom_range(0, 99);
            if (filling)
                c = (sel < 40) ? ple_pkg::CMD_APPEND : (sel < 75) ? ple_pkg::CMD_INSERT :
                    (sel < 90) ? ple_pkg::CMD_GET : ple_pkg::CMD_REMOVE;
            else
                c = (sel < 10) ? ple_pkg::CMD_APPEND : (sel < 25) ? ple_pkg::CMD_INSERT :
                    (sel < 45) ? ple_pkg::CMD_GET : ple_pkg::CMD_REMOVE;
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 31);
            else if (c == ple_pkg::CMD_INSERT)
                pos = $urandom_range(0, gen_len);
            else if (gen_len > 0)
                pos = $urandom_range(0, gen_len - 1);
            else
                pos = $urandom_range(0, 31);
            add_item(c, pos, random_word(), (n == 0) || ($urandom_range(0, 299) == 0));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("positional_list_engine_unit: match");
        else
            $display("positional_list_engine_unit: mismatch");
        $finish;
    end

endmodule
